// ===== sv/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared request codes and control structures of the point-in-polygon test.
// ----------------------------------------------------------------------------
package pip_pkg;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  // Smallest ring that can enclose anything
  localparam int unsigned MIN_RING = 3;

  // Walk control, aligned with the vertex read data
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } walk_ctl_t;

  // Edge pipeline result
  typedef struct packed {
    logic done;
    logic in_ring;
  } edge_res_t;

endpackage

// ===== sv/pip_ram.sv =====
// ----------------------------------------------------------------------------
// pip_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pip_edge.sv =====
// ----------------------------------------------------------------------------
// pip_edge
// Edge crossing pipeline: differences, exact cross products, compare, toggle.
// ----------------------------------------------------------------------------
module pip_edge import pip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  walk_ctl_t                     ctl_i,
  input  logic signed [COORD_WIDTH-1:0] vx_i,
  input  logic signed [COORD_WIDTH-1:0] vy_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  output edge_res_t                     res_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  // previous vertex of the ring
  logic signed [COORD_WIDTH-1:0] bx_q, by_q;

  logic signed [DW-1:0] dpx_q, dy_q, dbx_q, dpy_q;
  logic                 s1_vld_q, s1_hit_q, s1_last_q;

  logic signed [PW-1:0] lhs_q, rhs_q;
  logic                 s2_vld_q, s2_hit_q, s2_last_q, s2_dypos_q;

  logic inside_q;
  logic crosses, toggle;

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      bx_q  <= vx_i;
      by_q  <= vy_i;
      dpx_q <= DW'(px_i) - DW'(vx_i);
      dy_q  <= DW'(by_q) - DW'(vy_i);
      dbx_q <= DW'(bx_q) - DW'(vx_i);
      dpy_q <= DW'(py_i) - DW'(vy_i);
    end
    lhs_q      <= dpx_q * dy_q;
    rhs_q      <= dbx_q * dpy_q;
    s2_dypos_q <= !dy_q[DW-1] && (dy_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_hit_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_hit_q  <= 1'b0;
      s2_last_q <= 1'b0;
      inside_q  <= 1'b0;
    end else begin
      // the first read only primes the previous vertex
      s1_vld_q  <= ctl_i.vld && !ctl_i.first;
      s1_hit_q  <= (vy_i > py_i) != (by_q > py_i);
      s1_last_q <= ctl_i.last;
      s2_vld_q  <= s1_vld_q;
      s2_hit_q  <= s1_hit_q;
      s2_last_q <= s1_last_q;
      if (ctl_i.vld && ctl_i.first) begin
        inside_q <= 1'b0;
      end else if (toggle) begin
        inside_q <= !inside_q;
      end
    end
  end

  // direction of the compare follows the sign of dy
  assign crosses = s2_dypos_q ? (lhs_q < rhs_q) : (rhs_q < lhs_q);
  assign toggle  = s2_vld_q && s2_hit_q && crosses;

  assign res_o.done    = s2_vld_q && s2_last_q;
  assign res_o.in_ring = inside_q ^ toggle;

endmodule

// ===== sv/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd point-in-polygon test over a vertex ring held in RAM.
// ----------------------------------------------------------------------------
// Append, clear and unused request items, and queries on rings of fewer
// than three vertices, return their status item in the next cycle. A query
// on a ring of n >= 3 vertices reads the vertex RAM once per vertex plus
// once for the closing vertex, one read per cycle through the single RAM
// read port, and then drains the edge pipeline before its result item
// appears. No new item is taken while a query walks the ring or drains the
// pipeline, or while an unclaimed result is stalled.
// ----------------------------------------------------------------------------
module point_in_polygon_test import pip_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o,
  output logic [6:0]                    ring_size_o,
  output logic                          overflowed_o
);

  localparam int unsigned AW    = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned VW    = 2 * COORD_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] k_q, k_d;

  logic signed [COORD_WIDTH-1:0] px_q, py_q;

  logic       out_vld_q, out_vld_d;
  logic       out_in_q, out_in_d;
  logic [6:0] out_size_q, out_size_d;
  logic       out_ovf_q, out_ovf_d;

  walk_ctl_t ctl_d, ctl_q;
  edge_res_t res;

  logic          accept;
  req_e          req;
  logic          we;
  logic          re;
  logic [AW-1:0] raddr;
  logic [VW-1:0] rdata;
  logic          full;
  logic          short_ring;

  assign req        = req_e'(req_type_i);
  assign in_stall_o = (state_q != ST_IDLE) || (out_vld_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CNT_W'(MAX_VERTICES));
  assign short_ring = (cnt_q < CNT_W'(MIN_RING));
  assign we         = accept && (req == REQ_APPEND) && !full;

  // the closing vertex is read first, then vertex 0 onward
  assign re    = (state_q == ST_WALK);
  assign raddr = (k_q == '0) ? AW'(cnt_q - CNT_W'(1)) : AW'(k_q - CNT_W'(1));

  always_comb begin
    ctl_d.vld   = re;
    ctl_d.first = (k_q == '0);
    ctl_d.last  = (k_q == cnt_q);
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    k_d        = k_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_in_d   = out_in_q;
    out_size_d = out_size_q;
    out_ovf_d  = out_ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req)
            REQ_APPEND: begin
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            REQ_CLEAR: begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
            default: ;
          endcase
          if ((req == REQ_QUERY) && !short_ring) begin
            state_d = ST_WALK;
            k_d     = '0;
          end else begin
            out_vld_d  = 1'b1;
            out_in_d   = 1'b0;
            out_size_d = 7'(cnt_d);
            out_ovf_d  = ovf_d;
          end
        end
      end
      ST_WALK: begin
        k_d = k_q + CNT_W'(1);
        if (k_q == cnt_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res.done) begin
          state_d    = ST_IDLE;
          out_vld_d  = 1'b1;
          out_in_d   = res.in_ring;
          out_size_d = 7'(cnt_q);
          out_ovf_d  = ovf_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
      ctl_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
      ctl_q     <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    out_in_q   <= out_in_d;
    out_size_q <= out_size_d;
    out_ovf_q  <= out_ovf_d;
  end

  pip_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(AW'(cnt_q)),
    .wdata_i({coord_y_i, coord_x_i}),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  pip_edge #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_edge (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl_q),
    .vx_i  ($signed(rdata[COORD_WIDTH-1:0])),
    .vy_i  ($signed(rdata[VW-1:COORD_WIDTH])),
    .px_i  (px_q),
    .py_i  (py_q),
    .res_o (res)
  );

  assign out_valid_o  = out_vld_q;
  assign inside_res_o = out_in_q;
  assign ring_size_o  = out_size_q;
  assign overflowed_o = out_ovf_q;

endmodule
